/* design/nrm_pkg.sv */
// ----------------------------------------------------------------------------
// nrm_pkg: shared constants for the direction normalize and pack block
// Holds the snorm field geometry and the depth of the search pipeline.
// ----------------------------------------------------------------------------
`default_nettype none
package nrm_pkg;
    localparam int FIELD_W       = 10;  // width of one snorm field
    localparam int SEARCH_STEPS  = 9;   // one result bit per stage, 0..511
    localparam int PACK_W        = 3 * FIELD_W;
    localparam int OUT_TDATA_W   = ((PACK_W + 7) / 8) * 8;
endpackage
`default_nettype wire

/* design/nrm_prep.sv */
// ----------------------------------------------------------------------------
// nrm_prep: front end of the normalize pipeline
// Takes magnitudes, squares them and forms the squared length and the
// per-component targets 4*511^2*m^2, over three register stages.
// ----------------------------------------------------------------------------
`default_nettype none
module nrm_prep #(
    parameter int COMPONENT_WIDTH = 16,
    parameter int WW              = 2 * COMPONENT_WIDTH + 24
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              adv,
    input  wire logic                              in_valid,
    input  wire logic [2:0][COMPONENT_WIDTH-1:0]   comp,
    output logic                                   out_valid,
    output logic [WW-1:0]                          len_sq,
    output logic [2:0][WW-1:0]                     target,
    output logic [2:0]                             neg
);
    import nrm_pkg::*;

    localparam int W = COMPONENT_WIDTH;

    logic [2:0]            v_reg;
    logic [2:0][W-1:0]     mag_reg;
    logic [2:0]            neg_a_reg, neg_b_reg, neg_c_reg;
    logic [2:0][2*W-1:0]   sq_reg;
    logic [WW-1:0]         len_reg;
    logic [2:0][WW-1:0]    tgt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (adv) begin
            v_reg <= {v_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                // Two's complement magnitude; the most negative value maps exactly.
                neg_a_reg[i] <= comp[i][W-1];
                mag_reg[i]   <= comp[i][W-1] ? (~comp[i] + W'(1)) : comp[i];
                sq_reg[i]    <= mag_reg[i] * mag_reg[i];
                // 4*511^2 = 2^20 - 2^12 + 2^2
                tgt_reg[i]   <= (WW'(sq_reg[i]) << 20) - (WW'(sq_reg[i]) << 12)
                              + (WW'(sq_reg[i]) << 2);
            end
            neg_b_reg <= neg_a_reg;
            neg_c_reg <= neg_b_reg;
            len_reg   <= WW'(sq_reg[0]) + WW'(sq_reg[1]) + WW'(sq_reg[2]);
        end
    end

    assign out_valid = v_reg[2];
    assign len_sq    = len_reg;
    assign target    = tgt_reg;
    assign neg       = neg_c_reg;
endmodule
`default_nettype wire

/* design/nrm_step.sv */
// ----------------------------------------------------------------------------
// nrm_step: one stage of the snorm magnitude search
// Decides one bit of each quantized magnitude k by testing
// (2k-1)^2 * L <= target, with k^2*L and k*L kept incrementally.
// ----------------------------------------------------------------------------
`default_nettype none
module nrm_step #(
    parameter int WW  = 56,
    parameter int BIT = 8
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          adv,
    input  wire logic                          in_valid,
    input  wire logic [WW-1:0]                 in_len,
    input  wire logic [2:0][WW-1:0]            in_tgt,
    input  wire logic [2:0][WW-1:0]            in_p,
    input  wire logic [2:0][WW-1:0]            in_q,
    input  wire logic [2:0][nrm_pkg::SEARCH_STEPS-1:0] in_k,
    input  wire logic [2:0]                    in_neg,
    output logic                               out_valid,
    output logic [WW-1:0]                      out_len,
    output logic [2:0][WW-1:0]                 out_tgt,
    output logic [2:0][WW-1:0]                 out_p,
    output logic [2:0][WW-1:0]                 out_q,
    output logic [2:0][nrm_pkg::SEARCH_STEPS-1:0] out_k,
    output logic [2:0]                         out_neg
);
    import nrm_pkg::*;

    logic                          valid_reg;
    logic [WW-1:0]                 len_reg;
    logic [2:0][WW-1:0]            tgt_reg, p_reg, q_reg;
    logic [2:0][SEARCH_STEPS-1:0]  k_reg;
    logic [2:0]                    neg_reg;

    logic [2:0][WW-1:0]            p_try, q_try, lhs;
    logic [2:0]                    take;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            p_try[i] = in_p[i] + (in_q[i] << (BIT + 1)) + (in_len << (2 * BIT));
            q_try[i] = in_q[i] + (in_len << BIT);
            lhs[i]   = (p_try[i] << 2) - (q_try[i] << 2) + in_len;
            take[i]  = (lhs[i] <= in_tgt[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            len_reg <= in_len;
            tgt_reg <= in_tgt;
            neg_reg <= in_neg;
            for (int i = 0; i < 3; i++) begin
                p_reg[i] <= take[i] ? p_try[i] : in_p[i];
                q_reg[i] <= take[i] ? q_try[i] : in_q[i];
                k_reg[i] <= take[i] ? (in_k[i] | (SEARCH_STEPS'(1) << BIT)) : in_k[i];
            end
        end
    end

    assign out_valid = valid_reg;
    assign out_len   = len_reg;
    assign out_tgt   = tgt_reg;
    assign out_p     = p_reg;
    assign out_q     = q_reg;
    assign out_k     = k_reg;
    assign out_neg   = neg_reg;
endmodule
`default_nettype wire

/* design/direction_normalize_pack.sv */
// ----------------------------------------------------------------------------
// direction_normalize_pack: unit-length normalize and 10:10:10 snorm pack
// Normalizes a signed 3-component vector and packs it as three snorm fields.
// ----------------------------------------------------------------------------
// Usage:
//   The slave channel takes one vector per transaction: x, y and z are
//   packed in s_tdata from the lowest bit, COMPONENT_WIDTH bits each.
//   The master channel returns one transaction per input: m_tdata holds
//   the packed direction (x in bits 0-9, y in 10-19, z in 20-29) and
//   m_tuser is high when the vector was nonzero.
//   Each field is round(511*c/|v|), half away from zero, computed exactly.
//   The pipeline has three front-end stages (magnitude, square,
//   length and target), nine search stages that each settle one bit of
//   every quantized magnitude, and the output register.
//   Throughput is one transaction per cycle while m_tready does not stall;
//   the whole pipeline advances together whenever the output register is empty or being taken.
//   A stall on m_tready freezes every stage, so nothing is lost or repeated,
//   and s_tready drops in the same cycle.
//   Reset clears all stage valid bits; the pipeline comes up empty.
// ----------------------------------------------------------------------------
`default_nettype none
module direction_normalize_pack #(
    parameter int COMPONENT_WIDTH = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // x_component, y_component, z_component, then zero fill
    input  wire logic [((3*COMPONENT_WIDTH+7)/8)*8-1:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // packed_direction, then zero fill
    output logic [nrm_pkg::OUT_TDATA_W-1:0] m_tdata,
    // vector_valid
    output logic             m_tuser
);
    import nrm_pkg::*;

    localparam int W  = COMPONENT_WIDTH;
    localparam int WW = 2 * W + 24;

    // The pipeline moves as one when the output slot is free or draining.
    logic adv;
    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    logic [2:0][W-1:0] comp;
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            comp[i] = s_tdata[i*W +: W];
        end
    end

    // Stage signals between search steps; index 0 is the front-end output.
    logic                          v_pipe   [SEARCH_STEPS+1];
    logic [WW-1:0]                 len_pipe [SEARCH_STEPS+1];
    logic [2:0][WW-1:0]            tgt_pipe [SEARCH_STEPS+1];
    logic [2:0][WW-1:0]            p_pipe   [SEARCH_STEPS+1];
    logic [2:0][WW-1:0]            q_pipe   [SEARCH_STEPS+1];
    logic [2:0][SEARCH_STEPS-1:0]  k_pipe   [SEARCH_STEPS+1];
    logic [2:0]                    neg_pipe [SEARCH_STEPS+1];

    nrm_prep #(
        .COMPONENT_WIDTH (W),
        .WW              (WW)
    ) u_prep (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (s_tvalid),
        .comp      (comp),
        .out_valid (v_pipe[0]),
        .len_sq    (len_pipe[0]),
        .target    (tgt_pipe[0]),
        .neg       (neg_pipe[0])
    );

    // The search starts from k = 0, so k^2*L and k*L start at zero.
    assign p_pipe[0] = '0;
    assign q_pipe[0] = '0;
    assign k_pipe[0] = '0;

    for (genvar s = 0; s < SEARCH_STEPS; s++) begin : g_step
        nrm_step #(
            .WW  (WW),
            .BIT (SEARCH_STEPS - 1 - s)
        ) u_step (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .adv       (adv),
            .in_valid  (v_pipe[s]),
            .in_len    (len_pipe[s]),
            .in_tgt    (tgt_pipe[s]),
            .in_p      (p_pipe[s]),
            .in_q      (q_pipe[s]),
            .in_k      (k_pipe[s]),
            .in_neg    (neg_pipe[s]),
            .out_valid (v_pipe[s+1]),
            .out_len   (len_pipe[s+1]),
            .out_tgt   (tgt_pipe[s+1]),
            .out_p     (p_pipe[s+1]),
            .out_q     (q_pipe[s+1]),
            .out_k     (k_pipe[s+1]),
            .out_neg   (neg_pipe[s+1])
        );
    end

    // Pack: negate per sign into 10-bit two's complement; a zero vector
    // forces the whole word to zero and clears the valid flag.
    logic                 zero_vec;
    logic [PACK_W-1:0]    packed_next;
    always_comb begin
        zero_vec = (len_pipe[SEARCH_STEPS] == '0);
        for (int i = 0; i < 3; i++) begin
            packed_next[i*FIELD_W +: FIELD_W] =
                neg_pipe[SEARCH_STEPS][i]
                    ? FIELD_W'(-{1'b0, k_pipe[SEARCH_STEPS][i]})
                    : FIELD_W'({1'b0, k_pipe[SEARCH_STEPS][i]});
        end
        if (zero_vec) begin
            packed_next = '0;
        end
    end

    logic                 out_valid_reg;
    logic [PACK_W-1:0]    packed_reg;
    logic                 vec_ok_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= v_pipe[SEARCH_STEPS];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            packed_reg <= packed_next;
            vec_ok_reg <= !zero_vec;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_TDATA_W'(packed_reg);
    assign m_tuser  = vec_ok_reg;
endmodule
`default_nettype wire
